>>> hw/rtl/bvm_pkg.sv
// Shared types, constants and register codes for the battery voltage monitor.
`default_nettype none

package bvm_pkg;

    localparam int ADC_BITS   = 12;
    localparam int AVG_DEPTH  = 16;

    localparam int MV_W       = 15;
    localparam int PCT_W      = 7;
    localparam int UVPC_W     = 16;
    localparam int OHM_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int UV_PER_MV  = 1000;
    localparam int PCT_SCALE  = 100;
    localparam int PCT_MAX    = 100;
    localparam int MV_MAX     = 32767;

    localparam int AVG_AW     = $clog2(AVG_DEPTH);
    localparam int SUM_W      = MV_W + AVG_AW;
    localparam int PROD_W     = ADC_BITS + UVPC_W;
    // pin mV < 2^(ADC_BITS+16) / 1000 < 2^(ADC_BITS+7)
    localparam int PIN_W      = ADC_BITS + 7;
    localparam int TOPP_W     = OHM_W + PIN_W;
    localparam int LVL_W      = MV_W + $clog2(PCT_SCALE);

    // pin mV = (prod >> 3) / 125, the division by 125 as a reciprocal multiply,
    // exact for every RCP_IN_W-bit input
    localparam int PIN_PRE    = 3;
    localparam int UV_ODD     = UV_PER_MV >> PIN_PRE;
    localparam int RCP_IN_W   = PROD_W - PIN_PRE;
    localparam int RCP_SHIFT  = RCP_IN_W + $clog2(UV_ODD);
    localparam int RCP_W      = RCP_SHIFT - $clog2(UV_ODD) + 1;
    localparam int RCP_PROD_W = RCP_IN_W + RCP_W;
    localparam logic [RCP_W-1:0] PIN_RCP =
        RCP_W'(((64'd1 << RCP_SHIFT) + 64'(UV_ODD) - 64'd1) / 64'(UV_ODD));

    localparam int DIV_DW     = (TOPP_W > LVL_W) ? TOPP_W : LVL_W;
    localparam int DVS_W      = OHM_W;
    localparam int CNT_W      = $clog2(DIV_DW + 1);

    localparam int S_TDATA_W  = ((ADC_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 * MV_W + 2 * PCT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [UVPC_W-1:0] RST_UVPC  = UVPC_W'(805);
    localparam logic [OHM_W-1:0]  RST_TOP   = OHM_W'(100000);
    localparam logic [OHM_W-1:0]  RST_BOT   = OHM_W'(10000);
    localparam logic [MV_W-1:0]   RST_LMIN  = MV_W'(10000);
    localparam logic [MV_W-1:0]   RST_LMAX  = MV_W'(12600);
    localparam logic [MV_W-1:0]   RST_ACT   = MV_W'(11000);
    localparam logic [MV_W-1:0]   RST_DRIVE = MV_W'(10500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UVPC  = 3'd0,
        CFG_TOP   = 3'd1,
        CFG_BOT   = 3'd2,
        CFG_LMIN  = 3'd3,
        CFG_LMAX  = 3'd4,
        CFG_ACT   = 3'd5,
        CFG_DRIVE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [UVPC_W-1:0] uvpc;
        logic [OHM_W-1:0]  top;
        logic [OHM_W-1:0]  bot;
        logic [MV_W-1:0]   lmin;
        logic [MV_W-1:0]   lmax;
        logic [MV_W-1:0]   act;
        logic [MV_W-1:0]   drive;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DVS_W-1:0]  divisor;
        logic [CNT_W-1:0]  iters;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_PIN,
        S_RCP_PIN,
        S_MUL_TOP,
        S_DIV_TOP,
        S_SUM,
        S_AVG,
        S_MUL_LV,
        S_DIV_LV,
        S_MUL_LA,
        S_DIV_LA,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/bvm_cfg.sv
// Configuration register file with write decode.
`default_nettype none

module bvm_cfg (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [bvm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [bvm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bvm_pkg::t_cfg                  o_cfg
);

    bvm_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uvpc  <= bvm_pkg::RST_UVPC;
            r_cfg.top   <= bvm_pkg::RST_TOP;
            r_cfg.bot   <= bvm_pkg::RST_BOT;
            r_cfg.lmin  <= bvm_pkg::RST_LMIN;
            r_cfg.lmax  <= bvm_pkg::RST_LMAX;
            r_cfg.act   <= bvm_pkg::RST_ACT;
            r_cfg.drive <= bvm_pkg::RST_DRIVE;
        end else if (i_cfg_valid) begin
            unique case (bvm_pkg::t_cfg_idx'(i_cfg_index))
                bvm_pkg::CFG_UVPC:  r_cfg.uvpc  <= i_cfg_data[bvm_pkg::UVPC_W-1:0];
                bvm_pkg::CFG_TOP:   r_cfg.top   <= i_cfg_data[bvm_pkg::OHM_W-1:0];
                bvm_pkg::CFG_BOT:   r_cfg.bot   <= i_cfg_data[bvm_pkg::OHM_W-1:0];
                bvm_pkg::CFG_LMIN:  r_cfg.lmin  <= i_cfg_data[bvm_pkg::MV_W-1:0];
                bvm_pkg::CFG_LMAX:  r_cfg.lmax  <= i_cfg_data[bvm_pkg::MV_W-1:0];
                bvm_pkg::CFG_ACT:   r_cfg.act   <= i_cfg_data[bvm_pkg::MV_W-1:0];
                bvm_pkg::CFG_DRIVE: r_cfg.drive <= i_cfg_data[bvm_pkg::MV_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bvm_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module bvm_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  bvm_pkg::t_div_req   i_req,
    output bvm_pkg::t_div_rsp   o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [bvm_pkg::CNT_W-1:0]     r_cnt;
    logic [bvm_pkg::DIV_DW-1:0]    r_q;
    logic [bvm_pkg::DVS_W-1:0]     r_r;
    logic [bvm_pkg::DVS_W-1:0]     r_d;

    logic [bvm_pkg::DVS_W:0]       shifted;
    logic [bvm_pkg::DVS_W:0]       diff;
    logic                          ge;
    logic [bvm_pkg::DVS_W-1:0]     n_r;
    logic [bvm_pkg::DIV_DW-1:0]    n_q;
    logic                          last;

    // dividend is left-aligned by the caller, so the quotient ends in r_q
    always_comb begin
        shifted = {r_r, r_q[bvm_pkg::DIV_DW-1]};
        diff    = shifted - {1'b0, r_d};
        ge      = (shifted >= {1'b0, r_d});
        n_r     = ge ? diff[bvm_pkg::DVS_W-1:0] : shifted[bvm_pkg::DVS_W-1:0];
        n_q     = {r_q[bvm_pkg::DIV_DW-2:0], ge};
        last    = r_busy && (r_cnt == bvm_pkg::CNT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= last;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - bvm_pkg::CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("divider restarted while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with zero count");

endmodule

`default_nettype wire

>>> hw/rtl/battery_voltage_monitor.sv
// Battery voltage monitor top level: sequencer, datapath, history and output register.
// Sequence: three divisions on the shared serial divider and 8 other steps between input
//   transaction and output valid.
// Input is taken only in the idle state; a result waiting in the output register holds the
//   sequencer before its load, and input is taken again while that result waits.
// Reset: sync active low; history reads zero; sum, slot, ok, state, config, valid reset.
`default_nettype none

module battery_voltage_monitor (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [bvm_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [11:0] adc_sample
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // [14:0] voltage_mv, [29:15] average_mv, [36:30] level_pct,
    // [43:37] average_level_pct, [44] ok_to_drive
    output logic [bvm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [bvm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [bvm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    bvm_pkg::t_cfg     cfg;
    bvm_pkg::t_div_req div_req;
    bvm_pkg::t_div_rsp div_rsp;

    bvm_pkg::t_state   r_state;
    bvm_pkg::t_state   n_state;
    logic              r_start;
    logic              n_start;
    logic              load_out;

    logic [bvm_pkg::MV_W-1:0]      r_hist [bvm_pkg::AVG_DEPTH];
    logic [bvm_pkg::AVG_DEPTH-1:0] r_hist_vld;
    logic [bvm_pkg::AVG_AW-1:0]    r_slot;
    logic [bvm_pkg::SUM_W-1:0]     r_sum;
    logic                          r_ok;

    logic [bvm_pkg::ADC_BITS-1:0]  r_sample;
    logic [bvm_pkg::MV_W-1:0]      r_old;
    logic                          r_old_vld;
    logic [bvm_pkg::PROD_W-1:0]    r_prod;
    logic [bvm_pkg::PIN_W-1:0]     r_pin;
    logic [bvm_pkg::TOPP_W-1:0]    r_topp;
    logic [bvm_pkg::MV_W-1:0]      r_volt;
    logic [bvm_pkg::MV_W-1:0]      r_avg;
    logic [bvm_pkg::LVL_W-1:0]     r_lprod;
    logic                          r_lzero;
    logic [bvm_pkg::PCT_W-1:0]     r_lvl;
    logic [bvm_pkg::PCT_W-1:0]     r_alvl;
    logic                          r_out_vld;
    logic [bvm_pkg::M_TDATA_W-1:0] r_m_tdata;

    logic                          accept;
    logic [bvm_pkg::MV_W-1:0]      old_mv;
    logic [bvm_pkg::DIV_DW:0]      vsum;
    logic [bvm_pkg::MV_W-1:0]      span;
    logic [bvm_pkg::MV_W-1:0]      lvl_src;
    logic [bvm_pkg::MV_W-1:0]      lvl_diff;
    logic [bvm_pkg::MV_W-1:0]      avg_new;
    logic [bvm_pkg::RCP_PROD_W-1:0] rcp_prod;

    function automatic logic [bvm_pkg::PCT_W-1:0] lvl_pct(
        input logic [bvm_pkg::DIV_DW-1:0] q,
        input logic                       zero
    );
        logic [bvm_pkg::PCT_W-1:0] res;
        if (zero) begin
            res = '0;
        end else if (q > bvm_pkg::DIV_DW'(bvm_pkg::PCT_MAX)) begin
            res = bvm_pkg::PCT_W'(bvm_pkg::PCT_MAX);
        end else begin
            res = q[bvm_pkg::PCT_W-1:0];
        end
        return res;
    endfunction

    bvm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_start       = 1'b0;
        load_out      = 1'b0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            bvm_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = bvm_pkg::S_MUL_PIN;
                end
            end
            bvm_pkg::S_MUL_PIN: begin
                n_state = bvm_pkg::S_RCP_PIN;
            end
            bvm_pkg::S_RCP_PIN: begin
                n_state = bvm_pkg::S_MUL_TOP;
            end
            bvm_pkg::S_MUL_TOP: begin
                n_state = bvm_pkg::S_DIV_TOP;
                n_start = 1'b1;
            end
            bvm_pkg::S_DIV_TOP: begin
                if (div_rsp.done) begin
                    n_state = bvm_pkg::S_SUM;
                end
            end
            bvm_pkg::S_SUM: begin
                n_state = bvm_pkg::S_AVG;
            end
            bvm_pkg::S_AVG: begin
                n_state = bvm_pkg::S_MUL_LV;
            end
            bvm_pkg::S_MUL_LV: begin
                n_state = bvm_pkg::S_DIV_LV;
                n_start = 1'b1;
            end
            bvm_pkg::S_DIV_LV: begin
                if (div_rsp.done) begin
                    n_state = bvm_pkg::S_MUL_LA;
                end
            end
            bvm_pkg::S_MUL_LA: begin
                n_state = bvm_pkg::S_DIV_LA;
                n_start = 1'b1;
            end
            bvm_pkg::S_DIV_LA: begin
                if (div_rsp.done) begin
                    n_state = bvm_pkg::S_FINISH;
                end
            end
            bvm_pkg::S_FINISH: begin
                if (!r_out_vld || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = bvm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bvm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bvm_pkg::S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    // divider operand select, dividends left-aligned to the divider width
    always_comb begin
        div_req.start    = r_start;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.iters    = '0;
        case (r_state)
            bvm_pkg::S_DIV_TOP: begin
                div_req.dividend = bvm_pkg::DIV_DW'(r_topp)
                                   << (bvm_pkg::DIV_DW - bvm_pkg::TOPP_W);
                div_req.divisor  = cfg.bot;
                div_req.iters    = bvm_pkg::CNT_W'(bvm_pkg::TOPP_W);
            end
            bvm_pkg::S_DIV_LV, bvm_pkg::S_DIV_LA: begin
                div_req.dividend = bvm_pkg::DIV_DW'(r_lprod)
                                   << (bvm_pkg::DIV_DW - bvm_pkg::LVL_W);
                div_req.divisor  = bvm_pkg::DVS_W'(span);
                div_req.iters    = bvm_pkg::CNT_W'(bvm_pkg::LVL_W);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        accept   = s_axis_tvalid && s_axis_tready;
        old_mv   = r_old_vld ? r_old : '0;
        // zero bottom resistor gives an all-ones quotient, which saturates here too
        vsum     = {1'b0, div_rsp.quot} + (bvm_pkg::DIV_DW + 1)'(r_pin);
        span     = cfg.lmax - cfg.lmin;
        lvl_src  = (r_state == bvm_pkg::S_MUL_LV) ? r_volt : r_avg;
        lvl_diff = lvl_src - cfg.lmin;
        avg_new  = r_sum[bvm_pkg::SUM_W-1:bvm_pkg::AVG_AW];
        rcp_prod = bvm_pkg::RCP_PROD_W'(r_prod[bvm_pkg::PROD_W-1:bvm_pkg::PIN_PRE])
                   * bvm_pkg::RCP_PROD_W'(bvm_pkg::PIN_RCP);
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old <= r_hist[r_slot];
        end
        if (r_state == bvm_pkg::S_SUM) begin
            r_hist[r_slot] <= r_volt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
            r_slot     <= '0;
            r_sum      <= '0;
            r_ok       <= 1'b0;
        end else begin
            if (r_state == bvm_pkg::S_SUM) begin
                r_hist_vld[r_slot] <= 1'b1;
                r_sum <= r_sum - bvm_pkg::SUM_W'(old_mv) + bvm_pkg::SUM_W'(r_volt);
                if (r_slot == bvm_pkg::AVG_AW'(bvm_pkg::AVG_DEPTH - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + bvm_pkg::AVG_AW'(1);
                end
            end
            if (r_state == bvm_pkg::S_AVG) begin
                r_ok <= r_ok ? (avg_new > cfg.drive) : (avg_new > cfg.act);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample  <= s_axis_tdata[bvm_pkg::ADC_BITS-1:0];
            r_old_vld <= r_hist_vld[r_slot];
        end
        if (r_state == bvm_pkg::S_MUL_PIN) begin
            r_prod <= bvm_pkg::PROD_W'(r_sample) * bvm_pkg::PROD_W'(cfg.uvpc);
        end
        if (r_state == bvm_pkg::S_RCP_PIN) begin
            r_pin <= rcp_prod[bvm_pkg::RCP_SHIFT +: bvm_pkg::PIN_W];
        end
        if (r_state == bvm_pkg::S_MUL_TOP) begin
            r_topp <= bvm_pkg::TOPP_W'(cfg.top) * bvm_pkg::TOPP_W'(r_pin);
        end
        if (r_state == bvm_pkg::S_DIV_TOP && div_rsp.done) begin
            if (vsum > (bvm_pkg::DIV_DW + 1)'(bvm_pkg::MV_MAX)) begin
                r_volt <= bvm_pkg::MV_W'(bvm_pkg::MV_MAX);
            end else begin
                r_volt <= vsum[bvm_pkg::MV_W-1:0];
            end
        end
        if (r_state == bvm_pkg::S_AVG) begin
            r_avg <= avg_new;
        end
        if (r_state == bvm_pkg::S_MUL_LV || r_state == bvm_pkg::S_MUL_LA) begin
            r_lprod <= bvm_pkg::LVL_W'(lvl_diff) * bvm_pkg::LVL_W'(bvm_pkg::PCT_SCALE);
            r_lzero <= (cfg.lmax <= cfg.lmin) || (lvl_src <= cfg.lmin);
        end
        if (r_state == bvm_pkg::S_DIV_LV && div_rsp.done) begin
            r_lvl <= lvl_pct(div_rsp.quot, r_lzero);
        end
        if (r_state == bvm_pkg::S_DIV_LA && div_rsp.done) begin
            r_alvl <= lvl_pct(div_rsp.quot, r_lzero);
        end
        if (load_out) begin
            r_m_tdata <= bvm_pkg::M_TDATA_W'({r_ok, r_alvl, r_lvl, r_avg, r_volt});
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_m_tdata;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == bvm_pkg::S_MUL_PIN))
        else $error("accepted sample did not start the sequence");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == bvm_pkg::S_DIV_TOP || r_state == bvm_pkg::S_DIV_LV ||
                          r_state == bvm_pkg::S_DIV_LA))
        else $error("divider finished outside a divide step");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[36:30] <= 7'd100 && m_axis_tdata[43:37] <= 7'd100))
        else $error("level percent above one hundred");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_out_vld) |-> m_axis_tready)
        else $error("output register overwritten before transaction");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the battery voltage monitor: table-driven and random samples.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIRST_RANDOM  = 60;
    localparam int PHASE_ITEMS   = 63;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_AT       = 50;
    localparam int HOLD_CYCLES   = 600;

    typedef struct packed {
        logic                      ok_to_drive;
        logic [bvm_pkg::PCT_W-1:0] average_level_pct;
        logic [bvm_pkg::PCT_W-1:0] level_pct;
        logic [bvm_pkg::MV_W-1:0]  average_mv;
        logic [bvm_pkg::MV_W-1:0]  voltage_mv;
    } t_reading;

    typedef struct packed {
        logic [bvm_pkg::S_TDATA_W-1:0] raw;
        logic                          typed;
        t_reading                      want;
    } t_row;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [bvm_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;   // [11:0] adc_sample
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [14:0] voltage_mv, [29:15] average_mv, [36:30] level_pct,
    // [43:37] average_level_pct, [44] ok_to_drive
    logic [bvm_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    bvm_pkg::t_cfg_idx              i_cfg_index   = bvm_pkg::CFG_UVPC;
    logic [bvm_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;

    logic calm = 1'b0;   // no idling on either side while set
    int unsigned error_count = 0;

    // register mirror and averaging state
    bvm_pkg::t_cfg regs = '{uvpc: bvm_pkg::RST_UVPC, top: bvm_pkg::RST_TOP,
                            bot: bvm_pkg::RST_BOT, lmin: bvm_pkg::RST_LMIN,
                            lmax: bvm_pkg::RST_LMAX, act: bvm_pkg::RST_ACT,
                            drive: bvm_pkg::RST_DRIVE};
    logic [bvm_pkg::MV_W-1:0]   mv_history [bvm_pkg::AVG_DEPTH];
    logic [bvm_pkg::SUM_W-1:0]  mv_sum    = '0;
    logic [bvm_pkg::AVG_AW-1:0] next_slot = '0;
    logic                       drive_ok  = 1'b0;

    t_reading expected_readings[$];

    t_row directed_rows [0:22] = '{
        '{16'h0000, 1'b1, '0},
        '{16'h0FFF, 1'b1, '{1'b0, 7'd0, 7'd100, 15'd2047, 15'd32767}},
        '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0},
        '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0}, '{16'h0FFF, 1'b0, '0},
        '{16'h0AAA, 1'b0, '0}, '{16'h0555, 1'b0, '0}, '{16'h0001, 1'b0, '0},
        '{16'h0800, 1'b0, '0}, '{16'h07FF, 1'b0, '0},
        '{16'hF000, 1'b0, '0}, '{16'hA555, 1'b0, '0},   // bits above the sample ignored
        '{16'h0000, 1'b0, '0}, '{16'h0000, 1'b0, '0}, '{16'h0000, 1'b0, '0},
        '{16'h0000, 1'b0, '0}, '{16'h0000, 1'b0, '0}, '{16'h0000, 1'b0, '0},
        '{16'h0000, 1'b0, '0}, '{16'h0000, 1'b0, '0}
    };

    battery_voltage_monitor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        foreach (mv_history[k]) mv_history[k] = '0;
    end

    function automatic logic [bvm_pkg::MV_W-1:0] battery_mv(
        input logic [bvm_pkg::ADC_BITS-1:0] sample
    );
        longint unsigned pin;
        longint unsigned mv;
        pin = 64'(sample) * 64'(regs.uvpc) / 64'(bvm_pkg::UV_PER_MV);
        if (regs.bot == '0) begin
            return bvm_pkg::MV_W'(bvm_pkg::MV_MAX);
        end
        mv = 64'(regs.top) * pin / 64'(regs.bot) + pin;
        if (mv > 64'(bvm_pkg::MV_MAX)) begin
            mv = 64'(bvm_pkg::MV_MAX);
        end
        return bvm_pkg::MV_W'(mv);
    endfunction

    function automatic logic [bvm_pkg::PCT_W-1:0] charge_pct(
        input logic [bvm_pkg::MV_W-1:0] mv
    );
        longint unsigned pct;
        if (regs.lmax <= regs.lmin || mv <= regs.lmin) begin
            return '0;
        end
        pct = 64'(mv - regs.lmin) * 64'(bvm_pkg::PCT_SCALE) / 64'(regs.lmax - regs.lmin);
        if (pct > 64'(bvm_pkg::PCT_MAX)) begin
            pct = 64'(bvm_pkg::PCT_MAX);
        end
        return bvm_pkg::PCT_W'(pct);
    endfunction

    function automatic t_reading predict_reading(input logic [bvm_pkg::ADC_BITS-1:0] sample);
        t_reading r;
        logic [bvm_pkg::MV_W-1:0] mv;
        logic [bvm_pkg::MV_W-1:0] avg;
        mv = battery_mv(sample);
        mv_sum = mv_sum - bvm_pkg::SUM_W'(mv_history[next_slot]) + bvm_pkg::SUM_W'(mv);
        mv_history[next_slot] = mv;
        next_slot = next_slot + 1'b1;
        avg = bvm_pkg::MV_W'(mv_sum / bvm_pkg::AVG_DEPTH);
        if (!drive_ok) begin
            drive_ok = avg > regs.act;
        end else begin
            drive_ok = avg > regs.drive;
        end
        r.voltage_mv        = mv;
        r.average_mv        = avg;
        r.level_pct         = charge_pct(mv);
        r.average_level_pct = charge_pct(avg);
        r.ok_to_drive       = drive_ok;
        return r;
    endfunction

    task automatic log_error(input string msg);
        $display("[%0t] error: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input int unsigned idx);
        if (got != want) begin
            log_error($sformatf("reading %0d %s got %0d want %0d", idx, name, got, want));
        end
    endtask

    task automatic write_reg(input bvm_pkg::t_cfg_idx idx,
                             input logic [bvm_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            bvm_pkg::CFG_UVPC:  regs.uvpc  = bvm_pkg::UVPC_W'(val);
            bvm_pkg::CFG_TOP:   regs.top   = bvm_pkg::OHM_W'(val);
            bvm_pkg::CFG_BOT:   regs.bot   = bvm_pkg::OHM_W'(val);
            bvm_pkg::CFG_LMIN:  regs.lmin  = bvm_pkg::MV_W'(val);
            bvm_pkg::CFG_LMAX:  regs.lmax  = bvm_pkg::MV_W'(val);
            bvm_pkg::CFG_ACT:   regs.act   = bvm_pkg::MV_W'(val);
            bvm_pkg::CFG_DRIVE: regs.drive = bvm_pkg::MV_W'(val);
            default: ;
        endcase
    endtask

    task automatic load_regs(input bvm_pkg::t_cfg c);
        write_reg(bvm_pkg::CFG_UVPC,  bvm_pkg::CFG_DATA_W'(c.uvpc));
        write_reg(bvm_pkg::CFG_TOP,   bvm_pkg::CFG_DATA_W'(c.top));
        write_reg(bvm_pkg::CFG_BOT,   bvm_pkg::CFG_DATA_W'(c.bot));
        write_reg(bvm_pkg::CFG_LMIN,  bvm_pkg::CFG_DATA_W'(c.lmin));
        write_reg(bvm_pkg::CFG_LMAX,  bvm_pkg::CFG_DATA_W'(c.lmax));
        write_reg(bvm_pkg::CFG_ACT,   bvm_pkg::CFG_DATA_W'(c.act));
        write_reg(bvm_pkg::CFG_DRIVE, bvm_pkg::CFG_DATA_W'(c.drive));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [bvm_pkg::S_TDATA_W-1:0] raw, input logic typed,
                               input t_reading want);
        t_reading predicted;
        if (!calm && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 160)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = predict_reading(raw[bvm_pkg::ADC_BITS-1:0]);
        expected_readings.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        int walk;
        int unsigned pick;
        logic [bvm_pkg::ADC_BITS-1:0] sample;
        walk = int'($urandom_range(0, 4095));
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // slow drift so the average wanders across the thresholds
                walk = walk + int'($urandom_range(0, 400)) - 200;
                if (walk < 0) walk = 0;
                if (walk > 4095) walk = 4095;
                sample = bvm_pkg::ADC_BITS'(walk);
            end else if (pick < 85) begin
                sample = bvm_pkg::ADC_BITS'($urandom);
            end else if (pick < 93) begin
                sample = '0;
            end else begin
                sample = '1;
            end
            send_sample(bvm_pkg::S_TDATA_W'(sample), 1'b0, '0);
        end
    endtask

    // receiver: checks each result transaction, stalls at random, one long hold-off
    initial begin : receiver
        int unsigned hold_left;
        int unsigned taken;
        t_reading got;
        t_reading want;
        hold_left = 0;
        taken = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_reading'(m_axis_tdata[bvm_pkg::M_FIELDS_W-1:0]);
                taken++;
                if (expected_readings.size() == 0) begin
                    log_error($sformatf("reading %0d arrived with none expected", taken));
                end else begin
                    want = expected_readings.pop_front();
                    check_field("voltage_mv", got.voltage_mv, want.voltage_mv, taken);
                    check_field("average_mv", got.average_mv, want.average_mv, taken);
                    check_field("level_pct", got.level_pct, want.level_pct, taken);
                    check_field("average_level_pct", got.average_level_pct,
                                want.average_level_pct, taken);
                    check_field("ok_to_drive", got.ok_to_drive, want.ok_to_drive, taken);
                end
                if (taken == HOLD_AT) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    initial begin : stimulus
        bvm_pkg::t_cfg plan [0:8];
        plan[0] = '{uvpc: 16'hFFFF, top: 20'hFFFFF, bot: 20'd1, lmin: 15'd0,
                    lmax: 15'h7FFF, act: 15'h7FFF, drive: 15'h7FFF};
        plan[1] = '{uvpc: 16'd1, top: 20'd0, bot: 20'hFFFFF, lmin: 15'd0,
                    lmax: 15'd0, act: 15'd0, drive: 15'd0};
        // zero bottom resistor: voltage pinned at full scale
        plan[2] = '{uvpc: 16'd805, top: 20'd100000, bot: 20'd0, lmin: 15'd32000,
                    lmax: 15'd32766, act: 15'd20000, drive: 15'd15000};
        plan[3] = '{uvpc: 16'd0, top: 20'd54321, bot: 20'd777, lmin: 15'd100,
                    lmax: 15'd20000, act: 15'd5, drive: 15'd1};
        // empty level span, max below min
        plan[4] = '{uvpc: 16'd805, top: 20'd100000, bot: 20'd10000, lmin: 15'd20000,
                    lmax: 15'd5000, act: 15'd11000, drive: 15'd10500};
        plan[5] = '{uvpc: bvm_pkg::RST_UVPC, top: bvm_pkg::RST_TOP, bot: bvm_pkg::RST_BOT,
                    lmin: bvm_pkg::RST_LMIN, lmax: bvm_pkg::RST_LMAX,
                    act: bvm_pkg::RST_ACT, drive: bvm_pkg::RST_DRIVE};
        for (int p = 6; p < 9; p++) begin
            plan[p].uvpc  = bvm_pkg::UVPC_W'($urandom_range(200, 2000));
            plan[p].top   = bvm_pkg::OHM_W'($urandom_range(0, 150000));
            plan[p].bot   = bvm_pkg::OHM_W'($urandom_range(1, 40000));
            plan[p].lmin  = bvm_pkg::MV_W'($urandom_range(0, 32767));
            plan[p].lmax  = bvm_pkg::MV_W'($urandom_range(0, 32767));
            plan[p].act   = bvm_pkg::MV_W'($urandom_range(0, 32767));
            plan[p].drive = bvm_pkg::MV_W'($urandom_range(0, 32767));
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_sample(directed_rows[r].raw, directed_rows[r].typed, directed_rows[r].want);
        end
        send_random(FIRST_RANDOM);

        for (int p = 0; p < 9; p++) begin
            drain();
            calm <= (p == 0);
            load_regs(plan[p]);
            send_random(PHASE_ITEMS);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (expected_readings.size() != 0) begin
            void'(expected_readings.pop_front());
            log_error("expected reading never arrived");
        end
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4ms;
        $display("testbench failed");
        $finish;
    end

endmodule
